[rtl/indexed_doubly_linked_list_defines.svh]
// ----------------------------------------------------------------------------
// Indexed doubly linked list assertion macros
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_DEFINES_SVH

`ifndef ASSERT_OFF
`define IDLL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IDLL_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDLL_ASSERT(label, clk, rst, prop, msg)
`define IDLL_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

[rtl/idll_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed doubly linked list package
// Request and status codes, field widths and the node memory write enables.
// ----------------------------------------------------------------------------
package idll_pkg;

   localparam int DEF_SLOT_COUNT   = 256;
   localparam int DEF_VALUE_BITS   = 32;
   localparam int SLOT_FIELD_BITS  = 8;
   localparam int VALUE_FIELD_BITS = 32;
   localparam int COUNT_BITS       = 8;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_NEXT   = 2'd2,
      REQ_PREV   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_SLOT = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic value;
      logic next;
      logic prev;
   } mem_we_type;

endpackage

[rtl/indexed_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list: circular doubly linked list in a node memory
// One request in flight: a new request is taken only after the last result is
// registered, and its steps are set by the single read port and single write port
// of the node memory.
// Synchronous reset gives an empty list at once; no memory clearing pass.
// ----------------------------------------------------------------------------
`include "indexed_doubly_linked_list_defines.svh"

module indexed_doubly_linked_list #(
   parameter int SLOT_COUNT = idll_pkg::DEF_SLOT_COUNT,
   parameter int VALUE_BITS = idll_pkg::DEF_VALUE_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [1:0]                                   req_type,
   input  logic [idll_pkg::SLOT_FIELD_BITS-1:0]         req_slot_index,
   input  logic signed [idll_pkg::VALUE_FIELD_BITS-1:0] req_insert_value,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic [1:0]                                   rsp_status,
   output logic [idll_pkg::SLOT_FIELD_BITS-1:0]         rsp_result_slot,
   output logic signed [idll_pkg::VALUE_FIELD_BITS-1:0] rsp_result_value,
   output logic [idll_pkg::SLOT_FIELD_BITS-1:0]         rsp_head_slot,
   output logic [idll_pkg::SLOT_FIELD_BITS-1:0]         rsp_tail_slot,
   output logic [idll_pkg::COUNT_BITS-1:0]              rsp_live_count
);

   localparam int SLOT_BITS = $clog2(SLOT_COUNT);

   idll_pkg::mem_we_type  mem_we;
   logic [SLOT_BITS-1:0]  mem_wr_addr;
   logic [VALUE_BITS-1:0] mem_wr_value;
   logic [SLOT_BITS-1:0]  mem_wr_next;
   logic [SLOT_BITS-1:0]  mem_wr_prev;
   logic [SLOT_BITS-1:0]  mem_rd_addr;
   logic [VALUE_BITS-1:0] mem_rd_value;
   logic [SLOT_BITS-1:0]  mem_rd_next;
   logic [SLOT_BITS-1:0]  mem_rd_prev;

   idll_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_slot_index   (req_slot_index),
      .req_insert_value (req_insert_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_result_value (rsp_result_value),
      .rsp_head_slot    (rsp_head_slot),
      .rsp_tail_slot    (rsp_tail_slot),
      .rsp_live_count   (rsp_live_count),
      .mem_we           (mem_we),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_value     (mem_wr_value),
      .mem_wr_next      (mem_wr_next),
      .mem_wr_prev      (mem_wr_prev),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_value     (mem_rd_value),
      .mem_rd_next      (mem_rd_next),
      .mem_rd_prev      (mem_rd_prev)
   );

   idll_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .VALUE_BITS (VALUE_BITS)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (mem_wr_addr),
      .wr_value (mem_wr_value),
      .wr_next  (mem_wr_next),
      .wr_prev  (mem_wr_prev),
      .rd_addr  (mem_rd_addr),
      .rd_value (mem_rd_value),
      .rd_next  (mem_rd_next),
      .rd_prev  (mem_rd_prev)
   );

   `IDLL_ASSERT_RST(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "reset did not idle the block")
   `IDLL_ASSERT(a_no_write_on_accept, clock, reset, (req_valid && req_ready) |-> (mem_we == '0), "memory write during request transfer")
   `IDLL_ASSERT(a_no_sentinel_value, clock, reset, mem_we.value |-> (mem_wr_addr != '0), "data word written to the sentinel slot")

endmodule

[rtl/idll_mem.sv]
// ----------------------------------------------------------------------------
// Indexed doubly linked list node memory
// One entry per slot holding the data word and both links, with per-field
// write enables, one write port and one registered read port.
// ----------------------------------------------------------------------------
module idll_mem #(
   parameter int SLOT_COUNT = idll_pkg::DEF_SLOT_COUNT,
   parameter int VALUE_BITS = idll_pkg::DEF_VALUE_BITS
) (
   input  logic                          clock,
   input  idll_pkg::mem_we_type          wr_en,
   input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
   input  logic [VALUE_BITS-1:0]         wr_value,
   input  logic [$clog2(SLOT_COUNT)-1:0] wr_next,
   input  logic [$clog2(SLOT_COUNT)-1:0] wr_prev,
   input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
   output logic [VALUE_BITS-1:0]         rd_value,
   output logic [$clog2(SLOT_COUNT)-1:0] rd_next,
   output logic [$clog2(SLOT_COUNT)-1:0] rd_prev
);

   localparam int SLOT_BITS = $clog2(SLOT_COUNT);

   logic [VALUE_BITS-1:0] value_mem [SLOT_COUNT];
   logic [SLOT_BITS-1:0]  next_mem  [SLOT_COUNT];
   logic [SLOT_BITS-1:0]  prev_mem  [SLOT_COUNT];

   logic [VALUE_BITS-1:0] rd_value_ff;
   logic [SLOT_BITS-1:0]  rd_next_ff;
   logic [SLOT_BITS-1:0]  rd_prev_ff;

   always_ff @(posedge clock) begin
      if (wr_en.value) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_en.next) begin
         next_mem[wr_addr] <= wr_next;
      end
      if (wr_en.prev) begin
         prev_mem[wr_addr] <= wr_prev;
      end
      rd_value_ff <= value_mem[rd_addr];
      rd_next_ff  <= next_mem[rd_addr];
      rd_prev_ff  <= prev_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

[rtl/idll_ctrl.sv]
// ----------------------------------------------------------------------------
// Indexed doubly linked list sequencer
// Checks each request, walks the node memory through its read and write
// steps, keeps the free chain, live bits, head, tail and count, and holds
// the result register.
// ----------------------------------------------------------------------------
module idll_ctrl #(
   parameter int SLOT_COUNT = idll_pkg::DEF_SLOT_COUNT,
   parameter int VALUE_BITS = idll_pkg::DEF_VALUE_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [1:0]                                 req_type,
   input  logic [idll_pkg::SLOT_FIELD_BITS-1:0]       req_slot_index,
   input  logic signed [idll_pkg::VALUE_FIELD_BITS-1:0] req_insert_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [1:0]                                 rsp_status,
   output logic [idll_pkg::SLOT_FIELD_BITS-1:0]       rsp_result_slot,
   output logic signed [idll_pkg::VALUE_FIELD_BITS-1:0] rsp_result_value,
   output logic [idll_pkg::SLOT_FIELD_BITS-1:0]       rsp_head_slot,
   output logic [idll_pkg::SLOT_FIELD_BITS-1:0]       rsp_tail_slot,
   output logic [idll_pkg::COUNT_BITS-1:0]            rsp_live_count,
   output idll_pkg::mem_we_type                       mem_we,
   output logic [$clog2(SLOT_COUNT)-1:0]              mem_wr_addr,
   output logic [VALUE_BITS-1:0]                      mem_wr_value,
   output logic [$clog2(SLOT_COUNT)-1:0]              mem_wr_next,
   output logic [$clog2(SLOT_COUNT)-1:0]              mem_wr_prev,
   output logic [$clog2(SLOT_COUNT)-1:0]              mem_rd_addr,
   input  logic [VALUE_BITS-1:0]                      mem_rd_value,
   input  logic [$clog2(SLOT_COUNT)-1:0]              mem_rd_next,
   input  logic [$clog2(SLOT_COUNT)-1:0]              mem_rd_prev
);

   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int FILL_BITS   = $clog2(SLOT_COUNT + 1);
   localparam int ADDRESSABLE = 1 << idll_pkg::SLOT_FIELD_BITS;
   localparam int LIVE_DEPTH  = (SLOT_COUNT < ADDRESSABLE) ? SLOT_COUNT : ADDRESSABLE;
   localparam int LIVE_BITS   = $clog2(LIVE_DEPTH);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);
   localparam logic [SLOT_BITS-1:0] ONE_SLOT  = SLOT_BITS'(1);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_CHECK = 12'b0000_0000_0010,
      S_INS_A = 12'b0000_0000_0100,
      S_INS_B = 12'b0000_0000_1000,
      S_INS_C = 12'b0000_0001_0000,
      S_INS_D = 12'b0000_0010_0000,
      S_DEL_A = 12'b0000_0100_0000,
      S_DEL_B = 12'b0000_1000_0000,
      S_DEL_C = 12'b0001_0000_0000,
      S_QRY_A = 12'b0010_0000_0000,
      S_QRY_B = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type                              state_ff, state_in;
   idll_pkg::req_code_type                 op_ff, op_in;
   logic [idll_pkg::SLOT_FIELD_BITS-1:0]   slot_ff, slot_in;
   logic [VALUE_BITS-1:0]                  value_ff, value_in;
   logic [SLOT_BITS-1:0]                   free_head_ff, free_head_in;
   logic [FILL_BITS-1:0]                   fill_ff, fill_in;
   logic [idll_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic [SLOT_BITS-1:0]                   head_ff, head_in;
   logic [SLOT_BITS-1:0]                   tail_ff, tail_in;
   logic                                   live_ff [LIVE_DEPTH];
   logic                                   live_in [LIVE_DEPTH];
   logic [SLOT_BITS-1:0]                   link_a_ff, link_a_in;
   logic [SLOT_BITS-1:0]                   link_b_ff, link_b_in;
   logic [SLOT_BITS-1:0]                   res_slot_ff, res_slot_in;
   logic [VALUE_BITS-1:0]                  res_value_ff, res_value_in;
   idll_pkg::status_type                   res_status_ff, res_status_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   idll_pkg::status_type                   rsp_status_ff, rsp_status_in;
   logic [idll_pkg::SLOT_FIELD_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [idll_pkg::VALUE_FIELD_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [idll_pkg::SLOT_FIELD_BITS-1:0]   rsp_head_ff, rsp_head_in;
   logic [idll_pkg::SLOT_FIELD_BITS-1:0]   rsp_tail_ff, rsp_tail_in;
   logic [idll_pkg::COUNT_BITS-1:0]        rsp_count_ff, rsp_count_in;

   logic [SLOT_BITS-1:0] slot_addr;
   logic                 slot_zero;
   logic                 in_range;
   logic                 live_hit;
   logic                 anchor_ok;
   logic [SLOT_BITS-1:0] eff_next;
   logic [SLOT_BITS-1:0] eff_prev;
   logic [SLOT_BITS-1:0] query_link;
   logic                 fresh;
   logic [SLOT_BITS-1:0] fresh_next;
   logic                 cur_addressable;

   assign slot_addr  = SLOT_BITS'(slot_ff);
   assign slot_zero  = (slot_ff == '0);
   assign in_range   = (32'(slot_ff) < 32'(SLOT_COUNT));
   assign live_hit   = (32'(slot_ff) < 32'(LIVE_DEPTH)) && live_ff[slot_ff[LIVE_BITS-1:0]];
   assign anchor_ok  = in_range && (slot_zero || live_hit);
   assign eff_next   = slot_zero ? head_ff : mem_rd_next;
   assign eff_prev   = slot_zero ? tail_ff : mem_rd_prev;
   assign query_link = (op_ff == idll_pkg::REQ_NEXT) ? eff_next : eff_prev;

   // Slots at or above the fill mark were never written; their free-chain link is the next slot, or 0 after the last.
   assign fresh      = (FILL_BITS'(free_head_ff) >= fill_ff);
   assign fresh_next = (free_head_ff == LAST_SLOT) ? '0 : SLOT_BITS'(free_head_ff + ONE_SLOT);
   assign cur_addressable = (32'(free_head_ff) < 32'(LIVE_DEPTH));

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      value_in      = value_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      live_in       = live_ff;
      link_a_in     = link_a_ff;
      link_b_in     = link_b_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = '0;
      mem_wr_addr   = slot_addr;
      mem_wr_value  = value_ff;
      mem_wr_next   = '0;
      mem_wr_prev   = '0;
      mem_rd_addr   = slot_addr;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = idll_pkg::req_code_type'(req_type);
               slot_in  = req_slot_index;
               value_in = VALUE_BITS'($unsigned(req_insert_value));
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_slot_in   = '0;
            res_value_in  = '0;
            res_status_in = idll_pkg::STATUS_OK;
            if (!anchor_ok || (op_ff == idll_pkg::REQ_DELETE && slot_zero)) begin
               res_status_in = idll_pkg::STATUS_BAD_SLOT;
               state_in      = S_DONE;
            end else if (op_ff == idll_pkg::REQ_INSERT && free_head_ff == '0) begin
               res_status_in = idll_pkg::STATUS_FULL;
               state_in      = S_DONE;
            end else if (op_ff == idll_pkg::REQ_INSERT) begin
               state_in = S_INS_A;
            end else if (op_ff == idll_pkg::REQ_DELETE) begin
               state_in = S_DEL_A;
            end else begin
               state_in = S_QRY_A;
            end
         end
         S_INS_A: begin
            link_a_in   = eff_next;
            mem_rd_addr = free_head_ff;
            state_in    = S_INS_B;
         end
         S_INS_B: begin
            mem_we       = '{value: 1'b1, next: 1'b1, prev: 1'b1};
            mem_wr_addr  = free_head_ff;
            mem_wr_value = value_ff;
            mem_wr_next  = link_a_ff;
            mem_wr_prev  = slot_addr;
            free_head_in = fresh ? fresh_next : mem_rd_next;
            if (fresh) begin
               fill_in = FILL_BITS'(fill_ff + FILL_BITS'(1));
            end
            if (cur_addressable) begin
               live_in[free_head_ff[LIVE_BITS-1:0]] = 1'b1;
            end
            count_in     = count_ff + idll_pkg::COUNT_BITS'(1);
            res_slot_in  = free_head_ff;
            res_value_in = value_ff;
            state_in     = S_INS_C;
         end
         S_INS_C: begin
            mem_we      = '{value: 1'b0, next: 1'b0, prev: 1'b1};
            mem_wr_addr = link_a_ff;
            mem_wr_prev = res_slot_ff;
            state_in    = S_INS_D;
         end
         S_INS_D: begin
            mem_we      = '{value: 1'b0, next: 1'b1, prev: 1'b0};
            mem_wr_addr = slot_addr;
            mem_wr_next = res_slot_ff;
            state_in    = S_DONE;
         end
         S_DEL_A: begin
            link_a_in   = mem_rd_next;
            link_b_in   = mem_rd_prev;
            mem_we      = '{value: 1'b0, next: 1'b1, prev: 1'b0};
            mem_wr_addr = mem_rd_prev;
            mem_wr_next = mem_rd_next;
            state_in    = S_DEL_B;
         end
         S_DEL_B: begin
            mem_we      = '{value: 1'b0, next: 1'b0, prev: 1'b1};
            mem_wr_addr = link_a_ff;
            mem_wr_prev = link_b_ff;
            state_in    = S_DEL_C;
         end
         S_DEL_C: begin
            mem_we       = '{value: 1'b0, next: 1'b1, prev: 1'b1};
            mem_wr_addr  = slot_addr;
            mem_wr_next  = free_head_ff;
            mem_wr_prev  = '0;
            free_head_in = slot_addr;
            live_in[slot_ff[LIVE_BITS-1:0]] = 1'b0;
            count_in     = count_ff - idll_pkg::COUNT_BITS'(1);
            state_in     = S_DONE;
         end
         S_QRY_A: begin
            res_slot_in = query_link;
            mem_rd_addr = query_link;
            state_in    = S_QRY_B;
         end
         S_QRY_B: begin
            res_value_in = (res_slot_ff == '0) ? '0 : mem_rd_value;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = idll_pkg::SLOT_FIELD_BITS'(res_slot_ff);
               rsp_value_in  = idll_pkg::VALUE_FIELD_BITS'(res_value_ff);
               rsp_head_in   = idll_pkg::SLOT_FIELD_BITS'(head_ff);
               rsp_tail_in   = idll_pkg::SLOT_FIELD_BITS'(tail_ff);
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The sentinel links are kept in registers as the list head and tail.
      head_in = head_ff;
      tail_in = tail_ff;
      if (mem_we.next && mem_wr_addr == '0) begin
         head_in = mem_wr_next;
      end
      if (mem_we.prev && mem_wr_addr == '0) begin
         tail_in = mem_wr_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= ONE_SLOT;
         fill_ff      <= FILL_BITS'(1);
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LIVE_DEPTH; i++) begin
            live_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
         live_ff      <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      value_ff      <= value_in;
      link_a_ff     <= link_a_in;
      link_b_ff     <= link_b_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_slot  = rsp_slot_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_head_slot    = rsp_head_ff;
   assign rsp_tail_slot    = rsp_tail_ff;
   assign rsp_live_count   = rsp_count_ff;

endmodule
